// ===== hw/rtl/crlf_line_frame_receiver_defines.svh =====
// Assertion macros shared by the CR LF line frame receiver RTL.
// Standalone header; expects clk_i and rst_ni in the including scope.
`ifndef CRLF_LINE_FRAME_RECEIVER_DEFINES_SVH
`define CRLF_LINE_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property, checked outside reset.
`define CLFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define CLFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define CLFR_ASSERT(lbl, prop, msg)
`define CLFR_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/clfr_pkg.sv =====
// Package for the CR LF line frame receiver: sizes, codes and shared structs.
// No dependencies.
package clfr_pkg;

  // Line buffer depth, legal range 2 to 64.
  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);
  // Counter wide enough to hold BUF_DEPTH itself.
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

  // Fixed field widths.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 6;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;

  localparam logic [LEN_W-1:0] EXP_LEN_RST = 6'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX  = 2'd0,
    CMD_ACK = 2'd1,
    CMD_RD  = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  // Frame status as reported with each result.
  typedef struct packed {
    logic             done;
    logic             good;
    logic             err;
    logic [LEN_W-1:0] count;
  } status_t;

  // Line buffer access for one accepted transaction.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/crlf_line_frame_receiver.sv =====
// Top level of the CR LF line frame receiver: control state, line buffer RAM,
// status stage and output register. Depends on clfr_pkg, clfr_ctrl, clfr_ram, defines header.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, command, byte, index  | sink
//  cfg     | cfg_valid_i/cfg_ready_o, expected_length_i   | sink
//  out     | out_valid_o/out_ready_i, flags, count, data  | source
//
// One transaction per cycle sustained while the output is not stalled.
// State updates and the buffer write/read happen at the accept edge; the RAM
// read port registers the byte while the status waits in a holding stage.
// Reset clears all control state and the buffer valid bits at once; no sweep.
// A stalled output holds its transaction; the holding stage still takes one more.
// cfg is always ready; users must write cfg only while the block is idle (not enforced).
`include "crlf_line_frame_receiver_defines.svh"

module crlf_line_frame_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [clfr_pkg::CMD_W-1:0]   command_i,
  input  logic [clfr_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [clfr_pkg::IDX_W-1:0]   read_index_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [clfr_pkg::LEN_W-1:0]   expected_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         frame_done_o,
  output logic                         good_flag_o,
  output logic                         error_flag_o,
  output logic [clfr_pkg::LEN_W-1:0]   byte_count_o,
  output logic [clfr_pkg::BYTE_W-1:0]  read_data_o
);

  logic                        acc;
  clfr_pkg::status_t           stat_nxt;
  logic                        rd_hit;
  clfr_pkg::ram_req_t          ram_req;
  logic [clfr_pkg::BYTE_W-1:0] ram_rdata;

  // holding stage: status snapshot, waits for RAM read data
  logic                        s1_vld_q;
  clfr_pkg::status_t           s1_stat_q;
  logic                        s1_hit_q;
  logic                        s1_adv;

  // output register
  logic                        out_vld_q;
  clfr_pkg::status_t           out_stat_q;
  logic [clfr_pkg::BYTE_W-1:0] out_data_q;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !s1_vld_q || s1_adv;
  assign acc         = in_valid_i && in_ready_o;

  clfr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .read_index_i (read_index_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (expected_length_i),
    .stat_o       (stat_nxt),
    .rd_hit_o     (rd_hit),
    .ram_req_o    (ram_req)
  );

  clfr_ram #(
    .WIDTH (clfr_pkg::BYTE_W),
    .DEPTH (clfr_pkg::BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (rd_hit),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_stat_q <= stat_nxt;
      s1_hit_q  <= rd_hit;
    end
    if (s1_adv) begin
      out_stat_q <= s1_stat_q;
      out_data_q <= s1_hit_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign frame_done_o = out_stat_q.done;
  assign good_flag_o  = out_stat_q.good;
  assign error_flag_o = out_stat_q.err;
  assign byte_count_o = out_stat_q.count;
  assign read_data_o  = out_data_q;

  `CLFR_ASSERT(a_s1_hold,
    s1_vld_q && !s1_adv |=> s1_vld_q && $stable(s1_stat_q) && $stable(ram_rdata),
    "holding stage lost its transaction while stalled")
  `CLFR_ASSERT_IMPL(a_done_reported_good, out_vld_q && out_stat_q.done,
    out_stat_q.good && !out_stat_q.err, "done frame reported without good flag")
  `CLFR_ASSERT_IMPL(a_no_write_on_read, rd_hit, !ram_req.we,
    "buffer written and read by one transaction")

endmodule

// ===== hw/rtl/clfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/clfr_ctrl.sv =====
// Frame control state of the CR LF line frame receiver: count, CR seen,
// done and sticky flags, buffer valid bits. Depends on clfr_pkg and the defines header.
`include "crlf_line_frame_receiver_defines.svh"

module clfr_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [clfr_pkg::CMD_W-1:0]   command_i,
  input  logic [clfr_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [clfr_pkg::IDX_W-1:0]   read_index_i,
  input  logic                         cfg_we_i,
  input  logic [clfr_pkg::LEN_W-1:0]   cfg_data_i,
  output clfr_pkg::status_t            stat_o,
  output logic                         rd_hit_o,
  output clfr_pkg::ram_req_t           ram_req_o
);

  logic [clfr_pkg::CNT_W-1:0]     count_q, count_d, count_inc;
  logic                           cr_q, cr_d;
  logic                           done_q, done_d;
  logic                           good_q, good_d;
  logic                           err_q, err_d;
  logic [clfr_pkg::LEN_W-1:0]     exp_len_q;
  logic [clfr_pkg::BUF_DEPTH-1:0] vld_q, vld_d;
  logic                           rd_in_range;
  logic                           len_match;
  clfr_pkg::cmd_e                 cmd;

  assign cmd         = clfr_pkg::cmd_e'(command_i);
  assign count_inc   = count_q + clfr_pkg::CNT_W'(1);
  assign rd_in_range = (clfr_pkg::IDX_W+1)'(read_index_i)
                     < (clfr_pkg::IDX_W+1)'(clfr_pkg::BUF_DEPTH);
  assign len_match   = (clfr_pkg::IDX_W+1)'(count_q) == (clfr_pkg::IDX_W+1)'(exp_len_q);

  always_comb begin
    count_d   = count_q;
    cr_d      = cr_q;
    done_d    = done_q;
    good_d    = good_q;
    err_d     = err_q;
    vld_d     = vld_q;
    ram_req_o = '0;
    ram_req_o.waddr = count_q[clfr_pkg::ADDR_W-1:0];
    ram_req_o.wdata = data_byte_i;
    ram_req_o.raddr = read_index_i[clfr_pkg::ADDR_W-1:0];
    if (acc_i) begin
      unique case (cmd)
        clfr_pkg::CMD_RX: begin
          if (!done_q) begin
            if (cr_q) begin
              if (data_byte_i == clfr_pkg::CHAR_LF && len_match) begin
                done_d = 1'b1;
                good_d = 1'b1;
                err_d  = 1'b0;
              end else begin
                // bad terminator or wrong length: restart
                err_d   = 1'b1;
                count_d = '0;
                cr_d    = 1'b0;
                if (data_byte_i == clfr_pkg::CHAR_LF) begin
                  good_d = 1'b0;
                end
              end
            end else if (data_byte_i == clfr_pkg::CHAR_CR) begin
              cr_d = 1'b1;
            end else begin
              ram_req_o.we = 1'b1;
              vld_d[count_q[clfr_pkg::ADDR_W-1:0]] = 1'b1;
              if (count_inc == clfr_pkg::CNT_W'(clfr_pkg::BUF_DEPTH)) begin
                // overflow: bytes stay, count restarts
                err_d   = 1'b1;
                count_d = '0;
              end else begin
                count_d = count_inc;
              end
            end
          end
        end
        clfr_pkg::CMD_ACK: begin
          done_d  = 1'b0;
          good_d  = 1'b0;
          err_d   = 1'b0;
          count_d = '0;
          cr_d    = 1'b0;
        end
        clfr_pkg::CMD_RD: begin
          ram_req_o.re = rd_in_range;
        end
        clfr_pkg::CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Entries never written read as zero.
  assign rd_hit_o = ram_req_o.re && vld_q[ram_req_o.raddr];

  assign stat_o.done  = done_d;
  assign stat_o.good  = good_d;
  assign stat_o.err   = err_d;
  assign stat_o.count = clfr_pkg::LEN_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cr_q      <= 1'b0;
      done_q    <= 1'b0;
      good_q    <= 1'b0;
      err_q     <= 1'b0;
      vld_q     <= '0;
      exp_len_q <= clfr_pkg::EXP_LEN_RST;
    end else begin
      count_q <= count_d;
      cr_q    <= cr_d;
      done_q  <= done_d;
      good_q  <= good_d;
      err_q   <= err_d;
      vld_q   <= vld_d;
      if (cfg_we_i) begin
        exp_len_q <= cfg_data_i;
      end
    end
  end

  `CLFR_ASSERT(a_count_below_depth,
    count_q < clfr_pkg::CNT_W'(clfr_pkg::BUF_DEPTH), "count reached buffer depth")
  `CLFR_ASSERT_IMPL(a_done_flags, done_q, good_q && !err_q && cr_q,
    "held frame without good flag or CR")
  `CLFR_ASSERT_IMPL(a_done_holds, done_q && !(acc_i && cmd == clfr_pkg::CMD_ACK),
    !ram_req_o.we && done_d && count_d == count_q, "held frame modified by receive")

endmodule
